### rtl/twi_pkg.sv
// Shared constants and codes for the timed waypoint interpolator.
// No dependencies.
package twi_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int TIME_WIDTH_DEF  = 48;

    // Blend factor k is unsigned Q0.16; 1.0 needs one more bit.
    localparam int K_FRAC  = 16;
    localparam int K_WIDTH = K_FRAC + 1;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    typedef enum logic [2:0] {
        ST_MOVED = 3'd0,
        ST_ADDED = 3'd1,
        ST_ORDER = 3'd2,
        ST_FULL  = 3'd3,
        ST_EMPTY = 3'd4,
        ST_RATIO = 3'd5
    } status_t;

endpackage

### rtl/timed_waypoint_interpolator.sv
// Timed waypoint interpolator: queue of timed 3-D points, linear blend on tick.
// Add and start answer in the cycle after acceptance. Tick walks the queue entries
// through S_RD and S_CHK, checks the ratio in S_FIN, runs the serial divide in S_DIV
// and three multiply-adds in S_MUL and S_ADD; the divide is skipped when k is 0 or 1.
// One item at a time, stalled while a tick runs or a result waits; the walk uses the store's single read port.
// Asynchronous active-low reset empties the queue and zeroes the last point.
module timed_waypoint_interpolator #(
    parameter int QUEUE_DEPTH = twi_pkg::QUEUE_DEPTH_DEF,
    parameter int COORD_WIDTH = twi_pkg::COORD_WIDTH_DEF,
    parameter int TIME_WIDTH  = twi_pkg::TIME_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    mode,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [COORD_WIDTH-1:0] pos_z,
    input  logic [TIME_WIDTH-1:0]         event_time,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [2:0]                    status,
    output logic                          move_valid,
    output logic signed [COORD_WIDTH-1:0] target_x,
    output logic signed [COORD_WIDTH-1:0] target_y,
    output logic signed [COORD_WIDTH-1:0] target_z
);
    import twi_pkg::*;

    localparam int C    = COORD_WIDTH;
    localparam int T    = TIME_WIDTH;
    localparam int AW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int EW   = 3 * C + T;
    localparam int PW   = C + 1 + K_WIDTH + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_CHK, S_FIN, S_DIV, S_MUL, S_ADD
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   count_reg;
    logic [AW-1:0]   head_reg;
    logic [CW-1:0]   j_reg;
    logic            passed_reg;
    logic [T-1:0]    newest_reg;
    logic [T-1:0]    cur_reg;
    logic [1:0]      idx_reg;
    logic [K_WIDTH-1:0] k_reg;
    logic signed [PW-1:0] prod_reg;

    // last reached point, and the segment ends p1 (from) and p2 (to)
    logic [C-1:0] last_x_reg, last_y_reg, last_z_reg;
    logic [T-1:0] last_t_reg;
    logic [C-1:0] p1x_reg, p1y_reg, p1z_reg;
    logic [T-1:0] p1t_reg;
    logic [C-1:0] p2x_reg, p2y_reg, p2z_reg;
    logic [T-1:0] p2t_reg;

    logic         out_valid_reg;
    status_t      status_reg;
    logic         move_reg;
    logic [C-1:0] tx_reg, ty_reg, tz_reg;

    // store access
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;
    logic [C-1:0]  e_x, e_y, e_z;
    logic [T-1:0]  e_t;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [AW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= (AW + 1)'(QUEUE_DEPTH))
        begin
            s = s - (AW + 1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic req_acc;
    assign req_acc   = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE) || out_valid_reg;

    logic add_ok;
    assign add_ok = !((count_reg != '0) && (event_time < newest_reg))
                    && (count_reg != CW'(QUEUE_DEPTH));

    assign mem_we    = req_acc && (mode == MODE_ADD) && add_ok;
    assign mem_waddr = wrap_add(head_reg, count_reg[AW-1:0]);
    assign mem_raddr = wrap_add(head_reg, j_reg[AW-1:0]);

    twi_queue_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (EW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata ({pos_x, pos_y, pos_z, event_time}),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign {e_x, e_y, e_z, e_t} = mem_rdata;

    // segment ratio: elapsed and span, signed by their relation to p1
    logic         clamp;
    logic [T-1:0] cur_eff;
    logic         sa, sb;
    logic [T-1:0] ea, eb;
    logic         div_start;
    logic         div_done;
    logic [K_FRAC-1:0] div_q;

    always_comb
    begin
        clamp   = cur_reg >= p2t_reg;
        cur_eff = clamp ? p2t_reg : cur_reg;
        sa      = cur_eff < p1t_reg;
        ea      = sa ? (p1t_reg - cur_eff) : (cur_eff - p1t_reg);
        sb      = p2t_reg < p1t_reg;
        eb      = sb ? (p1t_reg - p2t_reg) : (p2t_reg - p1t_reg);
    end

    assign div_start = (state_reg == S_FIN) && (eb != '0) && (ea != '0)
                       && (sa == sb) && (ea < eb);

    twi_divider #(
        .TW (T)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (ea),
        .b     (eb),
        .done  (div_done),
        .q     (div_q)
    );

    // blend one coordinate: p1 + floor(k * (p2 - p1) / 2^16)
    logic [C-1:0]        sel_p1, sel_p2;
    logic signed [C:0]   diff;
    logic [C-1:0]        blended;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    begin sel_p1 = p1x_reg; sel_p2 = p2x_reg; end
            2'd1:    begin sel_p1 = p1y_reg; sel_p2 = p2y_reg; end
            default: begin sel_p1 = p1z_reg; sel_p2 = p2z_reg; end
        endcase
        diff    = $signed({sel_p2[C-1], sel_p2}) - $signed({sel_p1[C-1], sel_p1});
        blended = sel_p1 + prod_reg[K_FRAC+C-1:K_FRAC];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            j_reg         <= '0;
            passed_reg    <= 1'b0;
            idx_reg       <= '0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            last_z_reg    <= '0;
            last_t_reg    <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_MOVED;
            move_reg      <= 1'b0;
        end
        else
        begin
            // drop the result once taken
            if (rsp_valid && !rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_acc)
                    begin
                        unique case (mode)
                            MODE_ADD:
                            begin
                                out_valid_reg <= 1'b1;
                                move_reg      <= 1'b0;
                                tx_reg        <= '0;
                                ty_reg        <= '0;
                                tz_reg        <= '0;
                                if ((count_reg != '0) && (event_time < newest_reg))
                                begin
                                    status_reg <= ST_ORDER;
                                end
                                else if (count_reg == CW'(QUEUE_DEPTH))
                                begin
                                    status_reg <= ST_FULL;
                                end
                                else
                                begin
                                    status_reg <= ST_ADDED;
                                    count_reg  <= count_reg + 1'b1;
                                    newest_reg <= event_time;
                                end
                            end
                            MODE_START:
                            begin
                                last_x_reg    <= pos_x;
                                last_y_reg    <= pos_y;
                                last_z_reg    <= pos_z;
                                out_valid_reg <= 1'b1;
                                status_reg    <= ST_MOVED;
                                move_reg      <= 1'b1;
                                tx_reg        <= pos_x;
                                ty_reg        <= pos_y;
                                tz_reg        <= pos_z;
                            end
                            MODE_TICK:
                            begin
                                if (count_reg == '0)
                                begin
                                    out_valid_reg <= 1'b1;
                                    status_reg    <= ST_EMPTY;
                                    move_reg      <= 1'b0;
                                    tx_reg        <= '0;
                                    ty_reg        <= '0;
                                    tz_reg        <= '0;
                                end
                                else
                                begin
                                    cur_reg    <= event_time;
                                    j_reg      <= '0;
                                    passed_reg <= 1'b0;
                                    p1x_reg    <= last_x_reg;
                                    p1y_reg    <= last_y_reg;
                                    p1z_reg    <= last_z_reg;
                                    p1t_reg    <= last_t_reg;
                                    state_reg  <= S_RD;
                                end
                            end
                            default:
                            begin
                                // unused mode: no result
                            end
                        endcase
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    p2x_reg <= e_x;
                    p2y_reg <= e_y;
                    p2z_reg <= e_z;
                    p2t_reg <= e_t;
                    if (e_t >= cur_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        // entry lies behind the current time: it becomes p1
                        p1x_reg    <= e_x;
                        p1y_reg    <= e_y;
                        p1z_reg    <= e_z;
                        p1t_reg    <= e_t;
                        passed_reg <= 1'b1;
                        j_reg      <= j_reg + 1'b1;
                        state_reg  <= (j_reg + 1'b1 == count_reg) ? S_FIN : S_RD;
                    end
                end
                S_FIN:
                begin
                    last_x_reg <= p1x_reg;
                    last_y_reg <= p1y_reg;
                    last_z_reg <= p1z_reg;
                    last_t_reg <= p1t_reg;
                    if (passed_reg)
                    begin
                        head_reg <= wrap_add(head_reg, AW'(1));
                    end
                    if (clamp)
                    begin
                        count_reg <= '0;
                    end
                    else if (passed_reg)
                    begin
                        count_reg <= count_reg - 1'b1;
                    end
                    idx_reg <= '0;
                    if ((eb == '0) || (ea == eb && sa == sb))
                    begin
                        k_reg     <= K_WIDTH'(1) << K_FRAC;
                        state_reg <= S_MUL;
                    end
                    else if (ea == '0)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_MUL;
                    end
                    else if ((sa != sb) || (ea > eb))
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= ST_RATIO;
                        move_reg      <= 1'b0;
                        tx_reg        <= '0;
                        ty_reg        <= '0;
                        tz_reg        <= '0;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        k_reg     <= {1'b0, div_q};
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    unique case (idx_reg)
                        2'd0:    tx_reg <= blended;
                        2'd1:    ty_reg <= blended;
                        default: tz_reg <= blended;
                    endcase
                    if (idx_reg == 2'd2)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= ST_MOVED;
                        move_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // one multiply per coordinate, registered before the add
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
        begin
            prod_reg <= PW'(diff * $signed({1'b0, k_reg}));
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign status     = status_reg;
    assign move_valid = move_reg;
    assign target_x   = tx_reg;
    assign target_y   = ty_reg;
    assign target_z   = tz_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> (j_reg < count_reg))
        else $error("walk index past queue fill");

    a_no_move_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !move_valid) |-> (target_x == '0 && target_y == '0 && target_z == '0))
        else $error("targets not cleared without a move");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == S_DIV))
        else $error("divider started outside the ratio step");
`endif

endmodule

### rtl/twi_queue_mem.sv
// Waypoint store: one write port, one read port, registered read data.
// No dependencies.
module twi_queue_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 144
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/twi_divider.sv
// Restoring divider, one quotient bit a cycle: q = floor(a * 2^16 / b), a < b.
// Depends on twi_pkg.
module twi_divider #(
    parameter int TW = 48
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [TW-1:0]               a,
    input  logic [TW-1:0]               b,
    output logic                        done,
    output logic [twi_pkg::K_FRAC-1:0]  q
);
    import twi_pkg::*;

    localparam int CNT_W = $clog2(K_FRAC);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [TW:0]       rem_reg;
    logic [TW-1:0]     div_reg;
    logic [K_FRAC-1:0] q_reg;
    logic [TW:0]       shifted;
    logic              fits;

    assign shifted = {rem_reg[TW-1:0], 1'b0};
    assign fits    = shifted >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(K_FRAC - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, a};
            div_reg <= b;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (shifted - {1'b0, div_reg}) : shifted;
            q_reg   <= {q_reg[K_FRAC-2:0], fits};
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule
